// ===== design/ipfd_pkg.sv =====
// Package for the instrument packet field decoder.
// Holds the item and record types, protocol constants and the field id lookup.
package ipfd_pkg;

    localparam logic [7:0] MAX_PACKET_BYTES = 8'd128;
    localparam logic [7:0] HEADER_LAST_POS  = 8'd8;
    localparam logic [7:0] FIRST_FIELD_POS  = 8'd13;
    localparam logic [7:0] DATA_CATEGORY    = 8'h02;
    localparam logic [7:0] TYPE_SHORT       = 8'h04;
    localparam logic [7:0] TYPE_LONG        = 8'h05;
    localparam logic [2:0] END_SHORT        = 3'd5;
    localparam logic [2:0] END_LONG         = 3'd6;

    localparam logic [7:0] ID_DEPTH         = 8'h04;
    localparam logic [7:0] ID_APP_SPEED     = 8'h05;
    localparam logic [7:0] ID_APP_ANGLE     = 8'h06;
    localparam logic [7:0] ID_SUPPLY        = 8'h1b;
    localparam logic [7:0] ID_TRUE_SPEED    = 8'h21;
    localparam logic [7:0] ID_TRUE_ANGLE    = 8'h22;

    localparam logic [2:0] Q_DEPTH          = 3'd0;
    localparam logic [2:0] Q_APP_SPEED      = 3'd1;
    localparam logic [2:0] Q_APP_ANGLE      = 3'd2;
    localparam logic [2:0] Q_SUPPLY         = 3'd3;
    localparam logic [2:0] Q_TRUE_SPEED     = 3'd4;
    localparam logic [2:0] Q_TRUE_ANGLE     = 3'd5;

    localparam logic       KIND_HEADER      = 1'b0;
    localparam logic       KIND_UPDATE      = 1'b1;

    localparam int         NUM_QTY          = 6;
    localparam int         OUT_DATA_W       = 104;

    typedef struct packed {
        logic       last;
        logic [7:0] value;
    } t_byte;

    typedef struct packed {
        logic        kind;
        logic [5:0]  valid_mask;
        logic [15:0] reading;
        logic [2:0]  quantity;
        logic [7:0]  message_code;
        logic [7:0]  message_category;
        logic [23:0] device_id;
        logic [7:0]  device_type;
        logic [23:0] network_id;
    } t_rec;

    typedef struct packed {
        logic       hit;
        logic [2:0] qty;
    } t_qty_lookup;

    function automatic t_qty_lookup id_to_quantity(input logic [7:0] id);
        t_qty_lookup r;
        r.hit = 1'b1;
        r.qty = Q_DEPTH;
        unique case (id)
            ID_DEPTH:      r.qty = Q_DEPTH;
            ID_APP_SPEED:  r.qty = Q_APP_SPEED;
            ID_APP_ANGLE:  r.qty = Q_APP_ANGLE;
            ID_SUPPLY:     r.qty = Q_SUPPLY;
            ID_TRUE_SPEED: r.qty = Q_TRUE_SPEED;
            ID_TRUE_ANGLE: r.qty = Q_TRUE_ANGLE;
            default:       r.hit = 1'b0;
        endcase
        return r;
    endfunction

endpackage

// ===== design/ipfd_in_stage.sv =====
// Input register of the instrument packet field decoder.
// Depends on ipfd_pkg for the byte item type.
module ipfd_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  ipfd_pkg::t_byte i_item,
    input  logic           i_adv,
    output logic           o_valid,
    output ipfd_pkg::t_byte o_item
);
    import ipfd_pkg::*;

    logic  r_valid;
    t_byte r_item;

    assign o_ready = !r_valid || i_adv;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_adv) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

// ===== design/ipfd_parser.sv =====
// Packet parser: position counter, header capture, field checksum and store.
// Depends on ipfd_pkg for types, constants and the field id lookup.
module ipfd_parser (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  ipfd_pkg::t_byte i_item,
    output logic            o_rec_valid,
    output ipfd_pkg::t_rec  o_rec
);
    import ipfd_pkg::*;

    logic [7:0]  r_pos,   n_pos;
    logic [63:0] r_hdr,   n_hdr;
    logic [2:0]  r_fidx,  n_fidx;
    logic        r_long,  n_long;
    logic [7:0]  r_sum,   n_sum;
    logic [7:0]  r_code,  n_code;
    logic [15:0] r_val,   n_val;
    logic        r_stop,  n_stop;
    logic [5:0]  r_qvld,  n_qvld;

    t_qty_lookup lk;
    logic [2:0]  fend;
    logic [7:0]  b;

    assign b    = i_item.value;
    assign lk   = id_to_quantity(r_code);
    assign fend = r_long ? END_LONG : END_SHORT;

    always_comb begin
        n_pos  = r_pos;
        n_hdr  = r_hdr;
        n_fidx = r_fidx;
        n_long = r_long;
        n_sum  = r_sum;
        n_code = r_code;
        n_val  = r_val;
        n_stop = r_stop;
        n_qvld = r_qvld;
        o_rec_valid = 1'b0;
        o_rec  = '0;

        if (r_pos < MAX_PACKET_BYTES) begin
            if (r_pos < HEADER_LAST_POS) begin
                n_hdr = {r_hdr[55:0], b};
            end else if (r_pos == HEADER_LAST_POS) begin
                o_rec_valid            = 1'b1;
                o_rec.kind             = KIND_HEADER;
                o_rec.network_id       = r_hdr[63:40];
                o_rec.device_type      = r_hdr[39:32];
                o_rec.device_id        = r_hdr[31:8];
                o_rec.message_category = r_hdr[7:0];
                o_rec.message_code     = b;
            end else if (r_pos >= FIRST_FIELD_POS && r_hdr[7:0] == DATA_CATEGORY
                         && !r_stop) begin
                if (r_fidx == 3'd0) begin
                    if (b == TYPE_SHORT || b == TYPE_LONG) begin
                        n_long = (b == TYPE_LONG);
                        n_sum  = b;
                        n_fidx = 3'd1;
                    end else begin
                        n_stop = 1'b1;
                    end
                end else if (r_fidx >= fend) begin
                    if (b == r_sum && lk.hit) begin
                        n_qvld         = r_qvld | (6'd1 << lk.qty);
                        o_rec_valid    = 1'b1;
                        o_rec.kind     = KIND_UPDATE;
                        o_rec.quantity = lk.qty;
                        o_rec.reading  = r_val;
                    end
                    n_fidx = 3'd0;
                    n_sum  = '0;
                    n_code = '0;
                    n_val  = '0;
                end else begin
                    if (r_fidx == 3'd1) begin
                        n_code = b;
                    end else if (r_fidx == 3'd3) begin
                        n_val = {b, 8'd0};
                    end else if (r_fidx == 3'd4) begin
                        n_val = {r_val[15:8], b};
                    end
                    n_sum  = r_sum + b;
                    n_fidx = r_fidx + 3'd1;
                end
            end
            n_pos = r_pos + 8'd1;
        end

        o_rec.valid_mask = n_qvld;

        if (i_item.last) begin
            n_pos  = '0;
            n_hdr  = '0;
            n_fidx = '0;
            n_long = 1'b0;
            n_sum  = '0;
            n_code = '0;
            n_val  = '0;
            n_stop = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_hdr  <= '0;
            r_fidx <= '0;
            r_long <= 1'b0;
            r_sum  <= '0;
            r_code <= '0;
            r_val  <= '0;
            r_stop <= 1'b0;
            r_qvld <= '0;
        end else if (i_adv) begin
            r_pos  <= n_pos;
            r_hdr  <= n_hdr;
            r_fidx <= n_fidx;
            r_long <= n_long;
            r_sum  <= n_sum;
            r_code <= n_code;
            r_val  <= n_val;
            r_stop <= n_stop;
            r_qvld <= n_qvld;
        end
    end

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= MAX_PACKET_BYTES)
        else $error("position counter past limit");

    a_fidx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fidx <= END_LONG)
        else $error("field index past field end");

    a_valid_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_qvld & $past(r_qvld)) == $past(r_qvld))
        else $error("quantity valid flag dropped");

    a_fidx_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stop |-> r_fidx == 3'd0)
        else $error("field in progress after parse stop");

endmodule

// ===== design/ipfd_out_stage.sv =====
// Result register of the instrument packet field decoder.
// Depends on ipfd_pkg for the record type.
module ipfd_out_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  ipfd_pkg::t_rec i_rec,
    output logic           o_free,
    output logic           o_valid,
    input  logic           i_ready,
    output ipfd_pkg::t_rec o_rec
);
    import ipfd_pkg::*;

    logic r_valid;
    t_rec r_rec;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_rec   = r_rec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rec <= i_rec;
        end
    end

endmodule

// ===== design/instrument_packet_field_decoder.sv =====
// Top level of the instrument packet field decoder.
// Depends on ipfd_pkg, ipfd_in_stage, ipfd_parser and ipfd_out_stage.
//
// Takes one packet byte per cycle (tlast on the final byte) and returns a header
// record after byte 8 and one update record per field with a good checksum and
// a known id. Sustained rate is one byte per clock while the result side accepts:
// the input register, the parser and the result register each move one item a cycle,
// and a record passes the input register and then the result register. Stalls on
// the result side hold the input register and then drop s_tready.
module instrument_packet_field_decoder (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [7:0]                        i_s_tdata,  // byte_value
    input  logic                              i_s_tlast,  // last_byte
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // network_id, device_type, device_id, message_category, message_code,
    // quantity, reading, valid_mask, zero pad
    output logic [ipfd_pkg::OUT_DATA_W-1:0]   o_m_tdata,
    output logic                              o_m_tuser   // rec_kind
);
    import ipfd_pkg::*;

    t_byte s_item;
    t_byte p_item;
    logic  p_valid;
    logic  adv;
    logic  out_free;
    logic  rec_valid;
    t_rec  rec;
    t_rec  m_rec;

    assign s_item.value = i_s_tdata;
    assign s_item.last  = i_s_tlast;
    assign adv          = p_valid && out_free;

    ipfd_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_item  (s_item),
        .i_adv   (adv),
        .o_valid (p_valid),
        .o_item  (p_item)
    );

    ipfd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_item      (p_item),
        .o_rec_valid (rec_valid),
        .o_rec       (rec)
    );

    ipfd_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (adv && rec_valid),
        .i_rec   (rec),
        .o_free  (out_free),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_rec   (m_rec)
    );

    assign o_m_tuser = m_rec.kind;
    assign o_m_tdata = {7'd0, m_rec.valid_mask, m_rec.reading, m_rec.quantity,
                        m_rec.message_code, m_rec.message_category, m_rec.device_id,
                        m_rec.device_type, m_rec.network_id};

    a_update_qty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && m_rec.kind == KIND_UPDATE) |-> m_rec.quantity <= Q_TRUE_ANGLE)
        else $error("update record with bad quantity");

    a_update_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && m_rec.kind == KIND_UPDATE) |-> m_rec.valid_mask[m_rec.quantity])
        else $error("update record without its valid flag");

    a_header_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && m_rec.kind == KIND_HEADER) |-> (m_rec.quantity == 3'd0
        && m_rec.reading == 16'd0))
        else $error("header record carries update fields");

    a_update_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && m_rec.kind == KIND_UPDATE) |-> (m_rec.network_id == 24'd0
        && m_rec.device_id == 24'd0))
        else $error("update record carries header fields");

    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (p_valid && !out_free) |-> !o_s_tready)
        else $error("input taken while result side stalled");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for instrument_packet_field_decoder: streams hand-built and random packets
// and compares every header and update record against a behavioral packet decoder.
// Depends on ipfd_pkg and the decoder RTL only.
module tb_top;
    import ipfd_pkg::*;

    typedef struct packed {
        logic [6:0]  pad;
        logic [5:0]  valid_mask;
        logic [15:0] reading;
        logic [2:0]  quantity;
        logic [7:0]  message_code;
        logic [7:0]  message_category;
        logic [23:0] device_id;
        logic [7:0]  device_type;
        logic [23:0] network_id;
    } t_rec_word;

    typedef struct {
        logic      kind;
        t_rec_word word;
    } t_decoded_rec;

    typedef enum {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_BURSTY} t_ready_mode;

    class packet_scoreboard;
        logic [7:0]   byte_pos;
        logic [63:0]  hdr_bytes;
        logic [2:0]   fld_idx;
        logic         fld_long;
        logic [7:0]   fld_sum;
        logic [7:0]   fld_id;
        logic [15:0]  fld_value;
        logic         stopped;
        logic [5:0]   qty_valid;
        t_decoded_rec pending_recs[$];
        int           errors;

        function new();
            clear_packet();
            qty_valid = '0;
            errors    = 0;
        endfunction

        function void clear_packet();
            byte_pos  = '0;
            hdr_bytes = '0;
            fld_idx   = '0;
            fld_long  = 1'b0;
            fld_sum   = '0;
            fld_id    = '0;
            fld_value = '0;
            stopped   = 1'b0;
        endfunction

        function int field_quantity(logic [7:0] id);
            case (id)
                ID_DEPTH:      return Q_DEPTH;
                ID_APP_SPEED:  return Q_APP_SPEED;
                ID_APP_ANGLE:  return Q_APP_ANGLE;
                ID_SUPPLY:     return Q_SUPPLY;
                ID_TRUE_SPEED: return Q_TRUE_SPEED;
                ID_TRUE_ANGLE: return Q_TRUE_ANGLE;
                default:       return -1;
            endcase
        endfunction

        function void note_byte(logic [7:0] b, logic l);
            t_decoded_rec r;
            logic [2:0]   close_idx;
            int           q;
            r.kind = KIND_HEADER;
            r.word = '0;
            if (byte_pos < MAX_PACKET_BYTES) begin
                if (byte_pos < HEADER_LAST_POS) begin
                    hdr_bytes = {hdr_bytes[55:0], b};
                end else if (byte_pos == HEADER_LAST_POS) begin
                    r.word.network_id       = hdr_bytes[63:40];
                    r.word.device_type      = hdr_bytes[39:32];
                    r.word.device_id        = hdr_bytes[31:8];
                    r.word.message_category = hdr_bytes[7:0];
                    r.word.message_code     = b;
                    r.word.valid_mask       = qty_valid;
                    pending_recs.push_back(r);
                end else if (byte_pos >= FIRST_FIELD_POS && hdr_bytes[7:0] == DATA_CATEGORY
                             && !stopped) begin
                    close_idx = fld_long ? END_LONG : END_SHORT;
                    if (fld_idx == 3'd0) begin
                        if (b == TYPE_SHORT || b == TYPE_LONG) begin
                            fld_long = (b == TYPE_LONG);
                            fld_sum  = b;
                            fld_idx  = 3'd1;
                        end else begin
                            stopped = 1'b1;
                        end
                    end else if (fld_idx >= close_idx) begin
                        q = field_quantity(fld_id);
                        if (b == fld_sum && q >= 0) begin
                            qty_valid[q]      = 1'b1;
                            r.kind            = KIND_UPDATE;
                            r.word.quantity   = q[2:0];
                            r.word.reading    = fld_value;
                            r.word.valid_mask = qty_valid;
                            pending_recs.push_back(r);
                        end
                        fld_idx   = '0;
                        fld_sum   = '0;
                        fld_id    = '0;
                        fld_value = '0;
                    end else begin
                        if (fld_idx == 3'd1) begin
                            fld_id = b;
                        end else if (fld_idx == 3'd3) begin
                            fld_value = {b, 8'h00};
                        end else if (fld_idx == 3'd4) begin
                            fld_value[7:0] = b;
                        end
                        fld_sum = fld_sum + b;
                        fld_idx = fld_idx + 3'd1;
                    end
                end
                byte_pos = byte_pos + 8'd1;
            end
            if (l) begin
                clear_packet();
            end
        endfunction

        function void cmp_field(string name, logic [23:0] want, logic [23:0] seen);
            if (want !== seen) begin
                $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, seen);
                errors++;
            end
        endfunction

        function void check_record(t_rec_word got, logic kind);
            t_decoded_rec exp_rec;
            if (pending_recs.size() == 0) begin
                $display("%0t: unexpected record, expected none actual kind %0d data %h",
                         $time, kind, got);
                errors++;
                return;
            end
            exp_rec = pending_recs.pop_front();
            cmp_field("rec_kind", exp_rec.kind, kind);
            cmp_field("network_id", exp_rec.word.network_id, got.network_id);
            cmp_field("device_type", exp_rec.word.device_type, got.device_type);
            cmp_field("device_id", exp_rec.word.device_id, got.device_id);
            cmp_field("message_category", exp_rec.word.message_category,
                      got.message_category);
            cmp_field("message_code", exp_rec.word.message_code, got.message_code);
            cmp_field("quantity", exp_rec.word.quantity, got.quantity);
            cmp_field("reading", exp_rec.word.reading, got.reading);
            cmp_field("valid_mask", exp_rec.word.valid_mask, got.valid_mask);
            cmp_field("pad", exp_rec.word.pad, got.pad);
        endfunction
    endclass

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic [7:0]            i_s_tdata  = '0;
    logic                  i_s_tlast  = 1'b0;
    logic                  i_m_tready = 1'b0;
    wire                   o_s_tready;
    wire                   o_m_tvalid;
    wire [OUT_DATA_W-1:0]  o_m_tdata;
    wire                   o_m_tuser;

    packet_scoreboard sb;
    logic [7:0]       pkt[$];
    logic [7:0]       known_ids[6] = '{ID_DEPTH, ID_APP_SPEED, ID_APP_ANGLE,
                                       ID_SUPPLY, ID_TRUE_SPEED, ID_TRUE_ANGLE};
    int               burst_left    = 0;
    int               bytes_sent    = 0;
    int               packets_built = 0;
    t_ready_mode      ready_mode    = RDY_ALWAYS;
    int               ready_left    = 0;

    instrument_packet_field_decoder u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (ready_left == 0) begin
            ready_mode = t_ready_mode'($urandom_range(0, 3));
            ready_left = $urandom_range(16, 160);
        end else begin
            ready_left--;
        end
        case (ready_mode)
            RDY_ALWAYS: i_m_tready <= 1'b1;
            RDY_COIN:   i_m_tready <= 1'($urandom_range(0, 1));
            RDY_SPARSE: i_m_tready <= ($urandom_range(0, 3) == 0);
            default:    i_m_tready <= ((ready_left % 32) < 20);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                sb.note_byte(i_s_tdata, i_s_tlast);
            end
            if (o_m_tvalid && i_m_tready) begin
                sb.check_record(t_rec_word'(o_m_tdata), o_m_tuser);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic l);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
            burst_left = $urandom_range(1, 48);
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tlast  <= l;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        burst_left--;
        bytes_sent++;
    endtask

    task automatic send_packet();
        foreach (pkt[i]) begin
            send_byte(pkt[i], i == pkt.size() - 1);
        end
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (sb.pending_recs.size() != 0) @(posedge i_clk);
    endtask

    function automatic void add_field(input logic [7:0] ftype, input logic [7:0] fid,
                                      input logic [15:0] value, input logic bad_sum);
        logic [7:0] fb[$];
        logic [7:0] sum;
        fb = '{ftype, fid, 8'($urandom_range(0, 255)), value[15:8], value[7:0]};
        if (ftype == TYPE_LONG) begin
            fb.push_back(8'($urandom_range(0, 255)));
        end
        sum = '0;
        foreach (fb[i]) begin
            sum += fb[i];
            pkt.push_back(fb[i]);
        end
        if (bad_sum) begin
            sum += 8'($urandom_range(1, 255));
        end
        pkt.push_back(sum);
    endfunction

    task automatic build_random_packet();
        int          sel;
        int          nfields;
        int          target;
        logic [7:0]  b;
        logic [7:0]  fid;
        logic [15:0] value;
        logic        long_pkt;
        logic        halted;
        pkt.delete();
        sel = (packets_built == 25) ? 99 : $urandom_range(0, 99);
        packets_built++;
        if (sel < 8) begin
            repeat ($urandom_range(1, 8)) pkt.push_back(8'($urandom_range(0, 255)));
        end else if (sel < 18) begin
            repeat ($urandom_range(9, 40)) pkt.push_back(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 1)) begin
                pkt[7] = DATA_CATEGORY;
            end
        end else begin
            repeat (7) pkt.push_back(8'($urandom_range(0, 255)));
            if (sel < 28) begin
                do b = 8'($urandom_range(0, 255)); while (b == DATA_CATEGORY);
                pkt.push_back(b);
                repeat ($urandom_range(1, 24)) pkt.push_back(8'($urandom_range(0, 255)));
            end else begin
                pkt.push_back(DATA_CATEGORY);
                repeat (5) pkt.push_back(8'($urandom_range(0, 255)));
                long_pkt = (sel >= 97);
                target   = $urandom_range(MAX_PACKET_BYTES, MAX_PACKET_BYTES + 12);
                nfields  = long_pkt ? 40 : $urandom_range(0, 6);
                halted   = 1'b0;
                for (int f = 0; f < nfields && !halted; f++) begin
                    if ($urandom_range(0, 24) == 0) begin
                        do b = 8'($urandom_range(0, 255));
                        while (b == TYPE_SHORT || b == TYPE_LONG);
                        pkt.push_back(b);
                        repeat ($urandom_range(0, 8)) pkt.push_back(8'($urandom_range(0, 255)));
                        halted = 1'b1;
                    end else begin
                        case ($urandom_range(0, 5))
                            0:       value = 16'h8000;
                            1:       value = 16'h7fff;
                            default: value = 16'($urandom_range(0, 65535));
                        endcase
                        fid = ($urandom_range(0, 4) != 0) ? known_ids[$urandom_range(0, 5)]
                                                          : 8'($urandom_range(0, 255));
                        add_field($urandom_range(0, 1) ? TYPE_LONG : TYPE_SHORT, fid, value,
                                  $urandom_range(0, 9) == 0);
                    end
                end
                if (long_pkt) begin
                    while (pkt.size() < target) pkt.push_back(8'($urandom_range(0, 255)));
                    while (pkt.size() > target) void'(pkt.pop_back());
                end else if (pkt.size() > 14 && $urandom_range(0, 5) == 0) begin
                    repeat ($urandom_range(1, 5)) void'(pkt.pop_back());
                end
            end
        end
    endtask

    initial begin
        int  waited;
        logic paused;
        sb = new();
        paused = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        pkt = '{8'hff, 8'h00, 8'hff};
        send_packet();
        pkt = '{8'hff, 8'hff, 8'hff, 8'h00, 8'hff, 8'hff, 8'hff, DATA_CATEGORY, 8'hff,
                8'h00, 8'h00, 8'h00, 8'h00};
        add_field(TYPE_SHORT, ID_DEPTH, 16'h8000, 1'b0);
        add_field(TYPE_LONG, ID_TRUE_ANGLE, 16'h7fff, 1'b0);
        pkt.push_back(8'h00);
        send_packet();
        wait_drained();

        while (bytes_sent < 840) begin
            build_random_packet();
            send_packet();
            if (!paused && bytes_sent > 450) begin
                wait_drained();
                paused = 1'b1;
            end
        end
        i_s_tvalid <= 1'b0;

        waited = 0;
        while (sb.pending_recs.size() != 0 && waited < 4000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (8) @(posedge i_clk);
        if (sb.pending_recs.size() != 0) begin
            $display("%0t: %0d expected records never arrived", $time, sb.pending_recs.size());
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/ipfd_pkg.sv
design/ipfd_in_stage.sv
design/ipfd_parser.sv
design/ipfd_out_stage.sv
design/instrument_packet_field_decoder.sv
verif/tb_top.sv
